// ===== sv/dq_pkg.sv =====
// Shared types and codes for the double-ended queue.
package dq_pkg;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_BACK  = 3'd3,
    OP_LIST      = 3'd4
  } dq_op_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } dq_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LIST
  } dq_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic capture;    // latch request, start first ring read
    logic exec;       // perform operation, load result register
    logic list_emit;  // load next listed element
  } dq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;        // result register free or draining
    logic more_after_exec; // listing continues after first element
    logic more_after_step; // listing continues after current element
  } dq_sts_t;

  localparam int unsigned ValueW = 32;
  localparam int unsigned OccW   = 5;

endpackage

// ===== sv/dq_in_if.sv =====
// Request channel: operation and value.
interface dq_in_if
  import dq_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [2:0]        operation;
  logic [ValueW-1:0] value_in;

  modport source (output valid, output operation, output value_in, input ready);
  modport sink   (input valid, input operation, input value_in, output ready);
endinterface

// ===== sv/dq_out_if.sv =====
// Result channel: value, status, last marker and occupancy.
interface dq_out_if
  import dq_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value_out;
  logic [1:0]        status;
  logic              last;
  logic [OccW-1:0]   occupancy;

  modport source (output valid, output value_out, output status, output last,
                  output occupancy, input ready);
  modport sink   (input valid, input value_out, input status, input last,
                  input occupancy, output ready);
endinterface

// ===== sv/dq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/dq_ctrl.sv =====
// Controller state machine: sequences capture, execution and listing.
module dq_ctrl
  import dq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dq_sts_t sts_i,
  output dq_cmd_t cmd_o
);

  dq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = sts_i.more_after_exec ? S_LIST : S_IDLE;
        end
      end
      S_LIST: begin
        if (sts_i.out_free) begin
          cmd_o.list_emit = 1'b1;
          if (!sts_i.more_after_step) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== sv/dq_dp.sv =====
// Datapath: ring pointers, ring memory and result register.
module dq_dp
  import dq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dq_cmd_t           cmd_i,
  output dq_sts_t           sts_o,
  input  logic [2:0]        in_operation_i,
  input  logic [ValueW-1:0] in_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ValueW-1:0] out_value_o,
  output logic [1:0]        out_status_o,
  output logic              out_last_o,
  output logic [OccW-1:0]   out_occupancy_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [IW:0]   CapS = (IW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  // (a + b) mod CAPACITY for a and b below CAPACITY
  function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= CapS) begin
      s = s - CapS;
    end
    return s[IW-1:0];
  endfunction

  logic [IW-1:0]     front_q, front_d;
  logic [CW-1:0]     count_q, count_d;
  logic [IW-1:0]     idx_q, idx_d;
  dq_op_e            op_q;
  logic [ValueW-1:0] val_q;

  logic              out_valid_q, out_valid_d;
  logic [ValueW-1:0] out_value_q, out_value_d;
  dq_status_e        out_status_q, out_status_d;
  logic              out_last_q, out_last_d;
  logic [OccW-1:0]   out_occ_q, out_occ_d;

  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_waddr, ram_raddr, next_idx;
  logic [ValueW-1:0] ram_rdata;

  logic full, empty, load;
  dq_op_e in_op;

  assign full  = (count_q == CapC);
  assign empty = (count_q == '0);
  assign in_op = dq_op_e'(in_operation_i);
  assign load  = cmd_i.exec || cmd_i.list_emit;

  assign sts_o.out_free        = !out_valid_q || out_ready_i;
  assign sts_o.more_after_exec = (op_q == OP_LIST) && (count_q > CW'(1));
  assign sts_o.more_after_step = ((CW'(idx_q) + CW'(1)) != count_q);

  assign next_idx = cmd_i.exec ? IW'(1) : IW'(idx_q + 1'b1);

  // Read port: first access at capture, then one element per listing step.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = front_q;
    if (cmd_i.capture) begin
      ram_re = 1'b1;
      if (in_op == OP_REM_BACK) begin
        ram_raddr = ring_add(front_q, IW'(count_q - CW'(1)));
      end
    end else if ((cmd_i.exec && sts_o.more_after_exec) ||
                 (cmd_i.list_emit && sts_o.more_after_step)) begin
      ram_re    = 1'b1;
      ram_raddr = ring_add(front_q, next_idx);
    end
  end

  always_comb begin
    front_d      = front_q;
    count_d      = count_q;
    idx_d        = idx_q;
    ram_we       = 1'b0;
    ram_waddr    = ring_add(front_q, IW'(count_q));
    out_value_d  = '0;
    out_status_d = STS_OK;
    out_last_d   = 1'b1;
    if (cmd_i.exec) begin
      unique case (op_q) inside
        OP_INS_FRONT, OP_INS_BACK: begin
          if (full) begin
            out_status_d = STS_FULL;
          end else begin
            ram_we  = 1'b1;
            count_d = count_q + CW'(1);
            if (op_q == OP_INS_FRONT) begin
              front_d   = ring_add(front_q, IW'(CAPACITY - 1));
              ram_waddr = front_d;
            end
          end
        end
        OP_REM_FRONT, OP_REM_BACK: begin
          if (empty) begin
            out_status_d = STS_EMPTY;
          end else begin
            out_value_d = ram_rdata;
            count_d     = count_q - CW'(1);
            if (op_q == OP_REM_FRONT) begin
              front_d = ring_add(front_q, IW'(1));
            end
          end
        end
        OP_LIST: begin
          if (empty) begin
            out_status_d = STS_EMPTY;
          end else begin
            out_value_d = ram_rdata;
            out_last_d  = !sts_o.more_after_exec;
            idx_d       = next_idx;
          end
        end
        default: begin
          out_status_d = STS_OK;
        end
      endcase
    end else if (cmd_i.list_emit) begin
      out_value_d = ram_rdata;
      out_last_d  = !sts_o.more_after_step;
      idx_d       = next_idx;
    end
    out_occ_d = OccW'(count_d);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      front_q     <= front_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: hold request and result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= in_op;
      val_q <= in_value_i;
    end
    if (load) begin
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
      out_occ_q    <= out_occ_d;
    end
  end

  dq_ram #(
    .Width (ValueW),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (val_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign out_value_o     = out_value_q;
  assign out_status_o    = out_status_q;
  assign out_last_o      = out_last_q;
  assign out_occupancy_o = out_occ_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapC)
    else $error("element count exceeds capacity");

  a_front_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, front_q} < CapS)
    else $error("front index out of ring");

  a_full_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && full && (op_q == OP_INS_FRONT || op_q == OP_INS_BACK))
    |=> ($stable(count_q) && $stable(front_q)))
    else $error("refused insert changed queue state");

  a_list_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.list_emit && !sts_o.more_after_step) |=> (out_last_q && out_valid_q))
    else $error("final listed element not marked last");

endmodule

// ===== sv/double_ended_queue.sv =====
// Bounded double-ended queue over a ring memory, controller plus datapath.
// Insert and remove: the request is captured in S_IDLE, then the result register loads in S_EXEC
//   once it is free; a new request is taken only after the previous result has loaded.
// List: one ring read per element; an empty queue gives a single EMPTY result.
// A stalled result transfer holds the controller until the result register frees.
// Reset (rst_ni low, asynchronous) empties the queue; ring contents are not cleared.
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dq_in_if.sink    in_i,
  dq_out_if.source out_o
);

  dq_cmd_t cmd;
  dq_sts_t sts;

  dq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_operation_i  (in_i.operation),
    .in_value_i      (in_i.value_in),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .out_value_o     (out_o.value_out),
    .out_status_o    (out_o.status),
    .out_last_o      (out_o.last),
    .out_occupancy_o (out_o.occupancy)
  );

endmodule
